// ===== hw/rtl/lpst_pkg.sv =====
// ----------------------------------------------------------------------------
// lpst_pkg
// Shared constants and types for the linear prime sieve table unit.
// ----------------------------------------------------------------------------
package lpst_pkg;

    localparam int MAX_VALUE_DEF   = 16384;
    localparam int PRIME_SLOTS_DEF = 2048;

    localparam int VALUE_W     = 14;
    localparam int INDEX_W     = 11;
    localparam int COUNT_OUT_W = 12;
    localparam int OP_W        = 2;
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;

    localparam logic [VALUE_W-1:0]    LIMIT_RESET     = 14'd10000;
    localparam logic [APB_ADDR_W-1:0] REG_SIEVE_LIMIT = 2'd0;

    localparam logic [OP_W-1:0] OP_BUILD       = 2'd0;
    localparam logic [OP_W-1:0] OP_READ_PRIME  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_FACTOR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_V_RD,
        ST_V_CHK,
        ST_K_RD,
        ST_K_MUL,
        ST_K_WR,
        ST_RESP
    } lpst_state_t;

    // where the answer of a pending result comes from
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_PRIME,
        SRC_FACTOR
    } lpst_src_t;

    typedef struct packed {
        logic               building;
        logic [VALUE_W-1:0] limit;
    } lpst_stat_t;

endpackage

// ===== hw/rtl/lpst_ram.sv =====
// ----------------------------------------------------------------------------
// lpst_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lpst_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lpst_seq.sv =====
// ----------------------------------------------------------------------------
// lpst_seq
// Sequencer of the sieve: clears the factor memory, runs the linear sieve
// over both memories, serves reads and holds the result register.
// ----------------------------------------------------------------------------
module lpst_seq
    import lpst_pkg::*;
#(
    parameter int MAX_VALUE   = MAX_VALUE_DEF,
    parameter int PRIME_SLOTS = PRIME_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [VALUE_W-1:0]             cfg_limit,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [OP_W-1:0]                op,
    input  logic [INDEX_W-1:0]             prime_index,
    input  logic [VALUE_W-1:0]             query_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [VALUE_W-1:0]             answer,
    output logic [COUNT_OUT_W-1:0]         prime_count,
    output logic                           status,
    output logic                           fac_we,
    output logic [$clog2(MAX_VALUE)-1:0]   fac_waddr,
    output logic [VALUE_W-1:0]             fac_wdata,
    output logic                           fac_re,
    output logic [$clog2(MAX_VALUE)-1:0]   fac_raddr,
    input  logic [VALUE_W-1:0]             fac_rdata,
    output logic                           pl_we,
    output logic [$clog2(PRIME_SLOTS)-1:0] pl_waddr,
    output logic [VALUE_W-1:0]             pl_wdata,
    output logic                           pl_re,
    output logic [$clog2(PRIME_SLOTS)-1:0] pl_raddr,
    input  logic [VALUE_W-1:0]             pl_rdata,
    output lpst_stat_t                     stat
);

    localparam int AW  = $clog2(MAX_VALUE);
    localparam int PAW = $clog2(PRIME_SLOTS);
    localparam int CW  = $clog2(PRIME_SLOTS + 1);
    localparam int PW  = 2 * VALUE_W;

    lpst_state_t state_reg, state_next;
    logic [VALUE_W-1:0]     v_reg, v_next;
    logic [CW-1:0]          k_reg, k_next;
    logic [VALUE_W-1:0]     lim_reg, lim_next;
    logic [VALUE_W-1:0]     spf_reg, spf_next;
    logic [VALUE_W-1:0]     p_reg, p_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   built_reg, built_next;
    logic [VALUE_W-1:0]     blim_reg, blim_next;
    lpst_src_t              src_reg, src_next;
    logic                   err_reg, err_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     answer_reg, answer_next;
    logic [COUNT_OUT_W-1:0] pcount_reg, pcount_next;
    logic                   status_reg, status_next;
    logic [VALUE_W-1:0]     lim_eff;
    logic                   factor_ok;

    always_comb
    begin
        if (32'(cfg_limit) > MAX_VALUE - 1)
        begin
            lim_eff = VALUE_W'(MAX_VALUE - 1);
        end
        else
        begin
            lim_eff = cfg_limit;
        end
        factor_ok = built_reg && (query_value <= cfg_limit) &&
                    (32'(query_value) < MAX_VALUE);
    end

    always_comb
    begin
        state_next     = state_reg;
        v_next         = v_reg;
        k_next         = k_reg;
        lim_next       = lim_reg;
        spf_next       = spf_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        count_next     = count_reg;
        built_next     = built_reg;
        blim_next      = blim_reg;
        src_next       = src_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        answer_next    = answer_reg;
        pcount_next    = pcount_reg;
        status_next    = status_reg;
        fac_we         = 1'b0;
        fac_waddr      = '0;
        fac_wdata      = '0;
        fac_re         = 1'b0;
        fac_raddr      = '0;
        pl_we          = 1'b0;
        pl_waddr       = '0;
        pl_wdata       = '0;
        pl_re          = 1'b0;
        pl_raddr       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RESP;
                    src_next   = SRC_ZERO;
                    err_next   = 1'b1;
                    case (op)
                        OP_BUILD:
                        begin
                            lim_next   = lim_eff;
                            v_next     = '0;
                            count_next = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_READ_PRIME:
                        begin
                            if (built_reg && (32'(prime_index) < 32'(count_reg)))
                            begin
                                pl_re    = 1'b1;
                                pl_raddr = PAW'(prime_index);
                                src_next = SRC_PRIME;
                                err_next = 1'b0;
                            end
                        end
                        OP_READ_FACTOR:
                        begin
                            if (factor_ok)
                            begin
                                err_next = 1'b0;
                                // entries past the last build's limit still read as clear
                                if (query_value <= blim_reg)
                                begin
                                    fac_re    = 1'b1;
                                    fac_raddr = AW'(query_value);
                                    src_next  = SRC_FACTOR;
                                end
                            end
                        end
                        default:
                        begin
                            err_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                fac_we    = 1'b1;
                fac_waddr = AW'(v_reg);
                fac_wdata = '0;
                if (v_reg == lim_reg)
                begin
                    if (lim_reg < VALUE_W'(2))
                    begin
                        built_next = 1'b1;
                        blim_next  = lim_reg;
                        src_next   = SRC_ZERO;
                        err_next   = 1'b0;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        v_next     = VALUE_W'(2);
                        state_next = ST_V_RD;
                    end
                end
                else
                begin
                    v_next = v_reg + VALUE_W'(1);
                end
            end
            ST_V_RD:
            begin
                fac_re     = 1'b1;
                fac_raddr  = AW'(v_reg);
                k_next     = '0;
                state_next = ST_V_CHK;
            end
            ST_V_CHK:
            begin
                if (fac_rdata == '0)
                begin
                    spf_next = v_reg;
                    if (32'(count_reg) < PRIME_SLOTS)
                    begin
                        pl_we      = 1'b1;
                        pl_waddr   = PAW'(count_reg);
                        pl_wdata   = v_reg;
                        count_next = count_reg + CW'(1);
                    end
                end
                else
                begin
                    spf_next = fac_rdata;
                end
                state_next = ST_K_RD;
            end
            ST_K_RD:
            begin
                if (k_reg == count_reg)
                begin
                    if (v_reg == lim_reg)
                    begin
                        built_next = 1'b1;
                        blim_next  = lim_reg;
                        src_next   = SRC_ZERO;
                        err_next   = 1'b0;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        v_next     = v_reg + VALUE_W'(1);
                        state_next = ST_V_RD;
                    end
                end
                else
                begin
                    pl_re      = 1'b1;
                    pl_raddr   = PAW'(k_reg);
                    state_next = ST_K_MUL;
                end
            end
            ST_K_MUL:
            begin
                p_next     = pl_rdata;
                prod_next  = PW'(v_reg) * PW'(pl_rdata);
                state_next = ST_K_WR;
            end
            ST_K_WR:
            begin
                // p equal to the smallest factor of v is where v mod p first hits zero
                if ((prod_reg > PW'(lim_reg)) || (p_reg == spf_reg))
                begin
                    if (prod_reg <= PW'(lim_reg))
                    begin
                        fac_we    = 1'b1;
                        fac_waddr = AW'(prod_reg);
                        fac_wdata = p_reg;
                    end
                    if (v_reg == lim_reg)
                    begin
                        built_next = 1'b1;
                        blim_next  = lim_reg;
                        src_next   = SRC_ZERO;
                        err_next   = 1'b0;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        v_next     = v_reg + VALUE_W'(1);
                        state_next = ST_V_RD;
                    end
                end
                else
                begin
                    fac_we     = 1'b1;
                    fac_waddr  = AW'(prod_reg);
                    fac_wdata  = p_reg;
                    k_next     = k_reg + CW'(1);
                    state_next = ST_K_RD;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    pcount_next    = COUNT_OUT_W'(count_reg);
                    status_next    = err_reg;
                    case (src_reg)
                        SRC_PRIME:  answer_next = pl_rdata;
                        SRC_FACTOR: answer_next = fac_rdata;
                        default:    answer_next = '0;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            built_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            built_reg     <= built_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        k_reg      <= k_next;
        lim_reg    <= lim_next;
        spf_reg    <= spf_next;
        p_reg      <= p_next;
        prod_reg   <= prod_next;
        blim_reg   <= blim_next;
        src_reg    <= src_next;
        err_reg    <= err_next;
        answer_reg <= answer_next;
        pcount_reg <= pcount_next;
        status_reg <= status_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign answer        = answer_reg;
    assign prime_count   = pcount_reg;
    assign status        = status_reg;
    assign stat.building = (state_reg != ST_IDLE) && (state_reg != ST_RESP);
    assign stat.limit    = lim_reg;

endmodule

// ===== hw/rtl/linear_prime_sieve_table_unit.sv =====
// ----------------------------------------------------------------------------
// linear_prime_sieve_table_unit
// Prime and factor reads go through one factor or prime memory read, then the
// result register; a new read is taken only after the last result is registered.
// A build clears the factor table up to sieve_limit, then reads and checks each
// value and runs its marking steps (prime read, multiply, factor write); the
// factor memory has a single read port. Reset clears control state and loads the
// limit with 10000; memories are not cleared, a build clears the factor table.
// ----------------------------------------------------------------------------
module linear_prime_sieve_table_unit
    import lpst_pkg::*;
#(
    parameter int MAX_VALUE   = MAX_VALUE_DEF,
    parameter int PRIME_SLOTS = PRIME_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OP_W-1:0]        op,
    input  logic [INDEX_W-1:0]     prime_index,
    input  logic [VALUE_W-1:0]     query_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_W-1:0]     answer,
    output logic [COUNT_OUT_W-1:0] prime_count,
    output logic                   status,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int AW  = $clog2(MAX_VALUE);
    localparam int PAW = $clog2(PRIME_SLOTS);

    logic [VALUE_W-1:0] limit_reg;

    logic               fac_we;
    logic [AW-1:0]      fac_waddr;
    logic [VALUE_W-1:0] fac_wdata;
    logic               fac_re;
    logic [AW-1:0]      fac_raddr;
    logic [VALUE_W-1:0] fac_rdata;
    logic               pl_we;
    logic [PAW-1:0]     pl_waddr;
    logic [VALUE_W-1:0] pl_wdata;
    logic               pl_re;
    logic [PAW-1:0]     pl_raddr;
    logic [VALUE_W-1:0] pl_rdata;
    lpst_stat_t         stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_SIEVE_LIMIT))
        begin
            limit_reg <= pwdata[VALUE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_SIEVE_LIMIT) ? APB_DATA_W'(limit_reg) : '0;

    lpst_ram #(
        .DEPTH (MAX_VALUE),
        .WIDTH (VALUE_W)
    ) u_factor_ram (
        .clk   (clk),
        .we    (fac_we),
        .waddr (fac_waddr),
        .wdata (fac_wdata),
        .re    (fac_re),
        .raddr (fac_raddr),
        .rdata (fac_rdata)
    );

    lpst_ram #(
        .DEPTH (PRIME_SLOTS),
        .WIDTH (VALUE_W)
    ) u_prime_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .re    (pl_re),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    lpst_seq #(
        .MAX_VALUE   (MAX_VALUE),
        .PRIME_SLOTS (PRIME_SLOTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_limit   (limit_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .prime_index (prime_index),
        .query_value (query_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .answer      (answer),
        .prime_count (prime_count),
        .status      (status),
        .fac_we      (fac_we),
        .fac_waddr   (fac_waddr),
        .fac_wdata   (fac_wdata),
        .fac_re      (fac_re),
        .fac_raddr   (fac_raddr),
        .fac_rdata   (fac_rdata),
        .pl_we       (pl_we),
        .pl_waddr    (pl_waddr),
        .pl_wdata    (pl_wdata),
        .pl_re       (pl_re),
        .pl_raddr    (pl_raddr),
        .pl_rdata    (pl_rdata),
        .stat        (stat)
    );

    // an error beat never carries a nonzero answer
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> answer == '0)
        else $error("error beat with nonzero answer");

    // no item is taken while a build walks the memories
    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.building |-> !in_ready)
        else $error("input accepted during build");

    // factor writes stay inside the limit of the running build
    a_fac_range: assert property (@(posedge clk) disable iff (!rst_n)
        fac_we |-> (32'(fac_waddr) <= 32'(stat.limit)))
        else $error("factor write beyond build limit");

    // the factor memory is never read and written in the same cycle
    a_fac_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(fac_we && fac_re))
        else $error("factor memory read and write overlap");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for linear_prime_sieve_table_unit. A behavioral copy of the sieve
// predicts every result beat; directed checks cover reads before a build,
// range edges, limit changes with and without a rebuild and tiny limits,
// followed by randomized build-and-read phases with random handshake stalls.
// ----------------------------------------------------------------------------
module tb
    import lpst_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED       = 2'd3;
    localparam int unsigned     WATCHDOG_CYCLES = 600000;
    localparam int unsigned     RANDOM_ITEMS    = 1800;
    localparam int unsigned     REPORT_MAX      = 10;

    typedef struct {
        logic [VALUE_W-1:0]     answer;
        logic [COUNT_OUT_W-1:0] count;
        logic                   status;
    } answer_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [OP_W-1:0]        op;
    logic [INDEX_W-1:0]     prime_index;
    logic [VALUE_W-1:0]     query_value;
    logic                   out_valid;
    logic                   out_ready;
    logic [VALUE_W-1:0]     answer;
    logic [COUNT_OUT_W-1:0] prime_count;
    logic                   status;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // sieve state as the block should hold it
    int unsigned factor_ref [MAX_VALUE_DEF];
    int unsigned prime_ref  [PRIME_SLOTS_DEF];
    int unsigned primes_ref = 0;
    bit          sieve_done = 1'b0;
    int unsigned limit_reg  = 32'(LIMIT_RESET);

    answer_beat_t pending_answers [$];
    int unsigned  mismatches = 0;
    int unsigned  idle_max   = 8;
    int unsigned  quiet_cycles = 0;

    linear_prime_sieve_table_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .prime_index (prime_index),
        .query_value (query_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .answer      (answer),
        .prime_count (prime_count),
        .status      (status),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("mismatch %0s: expected %0d actual %0d", what, want, got);
        end
    endfunction

    function automatic void run_sieve_ref();
        int unsigned lim;
        int unsigned m;
        lim = (limit_reg > MAX_VALUE_DEF - 1) ? MAX_VALUE_DEF - 1 : limit_reg;
        foreach (factor_ref[i])
        begin
            factor_ref[i] = 0;
        end
        primes_ref = 0;
        for (int unsigned v = 2; v <= lim; v++)
        begin
            if (factor_ref[v] == 0 && primes_ref < PRIME_SLOTS_DEF)
            begin
                prime_ref[primes_ref] = v;
                primes_ref++;
            end
            // each composite is marked once, by its smallest prime factor
            for (int unsigned k = 0; k < primes_ref; k++)
            begin
                m = v * prime_ref[k];
                if (m > lim)
                    break;
                factor_ref[m] = prime_ref[k];
                if (v % prime_ref[k] == 0)
                    break;
            end
        end
        sieve_done = 1'b1;
    endfunction

    function automatic answer_beat_t sieve_predict(logic [OP_W-1:0] kind, int unsigned idx,
                                                   int unsigned val);
        answer_beat_t beat;
        beat.answer = '0;
        beat.status = 1'b0;
        case (kind)
            OP_BUILD:
                run_sieve_ref();
            OP_READ_PRIME:
                if (sieve_done && idx < primes_ref)
                    beat.answer = VALUE_W'(prime_ref[idx]);
                else
                    beat.status = 1'b1;
            OP_READ_FACTOR:
                // range check uses the current limit, not the one of the last build
                if (sieve_done && val <= limit_reg && val < MAX_VALUE_DEF)
                    beat.answer = VALUE_W'(factor_ref[val]);
                else
                    beat.status = 1'b1;
            default:
                beat.status = 1'b1;
        endcase
        beat.count = primes_ref[COUNT_OUT_W-1:0];
        return beat;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] kind, input int unsigned idx,
                             input int unsigned val);
        int unsigned  gap;
        answer_beat_t beat;
        gap = $urandom_range(0, idle_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= kind;
        prime_index <= idx[INDEX_W-1:0];
        query_value <= val[VALUE_W-1:0];
        do @(posedge clk); while (!in_ready);
        beat = sieve_predict(kind, 32'(idx[INDEX_W-1:0]), 32'(val[VALUE_W-1:0]));
        pending_answers.insert(pending_answers.size(), beat);
    endtask

    // let every outstanding beat come back before touching the register
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SIEVE_LIMIT;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        limit_reg = 32'(data[VALUE_W-1:0]);
        // read back
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[VALUE_W-1:0] !== limit_reg[VALUE_W-1:0])
            note_mismatch("sieve_limit readback", limit_reg, 32'(prdata[VALUE_W-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reads_before_build();
        send_item(OP_READ_PRIME, 0, 0);
        send_item(OP_READ_FACTOR, 0, 0);
        send_item(OP_READ_FACTOR, 2047, 10000);
        send_item(OP_UNUSED, 2047, 16383);
    endtask

    task automatic check_default_build();
        idle_max = 0;
        send_item(OP_BUILD, 0, 0);
        idle_max = 8;
        send_item(OP_READ_PRIME, 0, 0);
        send_item(OP_READ_PRIME, 1228, 0);
        send_item(OP_READ_PRIME, 1229, 0);
        send_item(OP_READ_PRIME, 2047, 16383);
        send_item(OP_READ_FACTOR, 0, 4);
        send_item(OP_READ_FACTOR, 0, 9973);
        send_item(OP_READ_FACTOR, 0, 9999);
        send_item(OP_READ_FACTOR, 0, 10000);
        send_item(OP_READ_FACTOR, 0, 10001);
        send_item(OP_READ_FACTOR, 0, 16383);
    endtask

    task automatic check_limit_changes();
        settle_block();
        write_limit(32'd100);
        send_item(OP_READ_FACTOR, 0, 100);
        send_item(OP_READ_FACTOR, 0, 101);
        settle_block();
        // raised without rebuild: values past the old limit read as zero
        write_limit(32'hFFFF_FFFF);
        send_item(OP_READ_FACTOR, 0, 12000);
        send_item(OP_BUILD, 0, 0);
        send_item(OP_READ_PRIME, 1899, 0);
        send_item(OP_READ_FACTOR, 0, 16383);
        send_item(OP_READ_FACTOR, 0, 16381);
    endtask

    task automatic check_tiny_limits();
        settle_block();
        write_limit(32'hFFFF_C000);
        send_item(OP_BUILD, 2047, 16383);
        send_item(OP_READ_PRIME, 0, 0);
        send_item(OP_READ_FACTOR, 0, 0);
        send_item(OP_READ_FACTOR, 0, 1);
        settle_block();
        write_limit(32'd2);
        send_item(OP_BUILD, 0, 0);
        send_item(OP_READ_PRIME, 0, 0);
        send_item(OP_READ_PRIME, 1, 0);
        send_item(OP_READ_FACTOR, 0, 3);
    endtask

    task automatic check_random_traffic();
        int unsigned sent;
        int unsigned phase;
        int unsigned reads;
        int unsigned pick;
        int unsigned idx;
        int unsigned val;
        logic [APB_DATA_W-1:0] data;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle_block();
            idle_max = (phase % 3 == 0) ? 0 : 8;
            pick = $urandom_range(0, 9);
            data = $urandom();
            if (phase == 0)
                data[VALUE_W-1:0] = VALUE_W'($urandom_range(2000, 16383));
            else if (pick == 0)
                data[VALUE_W-1:0] = VALUE_W'($urandom_range(0, 3));
            else if (pick == 1)
                data[VALUE_W-1:0] = VALUE_W'($urandom_range(600, 3000));
            else
                data[VALUE_W-1:0] = VALUE_W'($urandom_range(2, 600));
            data[APB_DATA_W-1:VALUE_W] = (APB_DATA_W - VALUE_W)'($urandom());
            write_limit(data);
            // now and then keep the old table to read across a limit change
            if (phase == 0 || $urandom_range(0, 6) != 0)
            begin
                send_item(OP_BUILD, $urandom_range(0, 2047), $urandom_range(0, 16383));
                sent++;
            end
            reads = $urandom_range(20, 60);
            repeat (reads)
            begin
                pick = $urandom_range(0, 99);
                idx  = $urandom_range(0, 2047);
                val  = $urandom_range(0, 16383);
                if (pick < 45)
                begin
                    if (primes_ref > 0 && $urandom_range(0, 4) != 0)
                        idx = $urandom_range(0, primes_ref - 1);
                    send_item(OP_READ_PRIME, idx, val);
                end
                else if (pick < 90)
                begin
                    if ($urandom_range(0, 4) != 0)
                        val = $urandom_range(0, limit_reg);
                    send_item(OP_READ_FACTOR, idx, val);
                end
                else if (pick < 95 || limit_reg > 3000)
                    send_item(OP_UNUSED, idx, val);
                else
                    send_item(OP_BUILD, idx, val);
                sent++;
            end
            phase++;
        end
    endtask

    initial
    begin : result_sink
        int unsigned stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, idle_max);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : check_results
        answer_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                note_mismatch("unexpected beat, answer", 0, 32'(answer));
            end
            else
            begin
                want = pending_answers.pop_front();
                if (answer !== want.answer)
                    note_mismatch("answer", 32'(want.answer), 32'(answer));
                if (prime_count !== want.count)
                    note_mismatch("prime_count", 32'(want.count), 32'(prime_count));
                if (status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(status));
            end
        end
    end

    // a full-size build is the longest stretch without a beat
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin : main_flow
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_BUILD;
        prime_index = '0;
        query_value = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = REG_SIEVE_LIMIT;
        pwdata      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_reads_before_build();
        check_default_build();
        check_limit_changes();
        check_tiny_limits();
        check_random_traffic();

        settle_block();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== linear_prime_sieve_table_unit.f =====
hw/rtl/lpst_pkg.sv
hw/rtl/lpst_ram.sv
hw/rtl/lpst_seq.sv
hw/rtl/linear_prime_sieve_table_unit.sv
test/tb.sv
